### hw/rtl/flash_plane_block_list_gc_victim_unit_defines.svh
// Assertion macros shared by the flash plane block list and GC victim unit.
`ifndef FLASH_PLANE_BLOCK_LIST_GC_VICTIM_UNIT_DEFINES_SVH
`define FLASH_PLANE_BLOCK_LIST_GC_VICTIM_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FPGC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FPGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FPGC_ASSERT_IMPL(lbl, ante, cons, msg)
`define FPGC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hw/rtl/fpgc_pkg.sv
// Constants, types and helper functions of the flash plane block list unit.
`default_nettype none

package fpgc_pkg;

    // Geometry
    localparam int BLOCKS          = 1024;
    localparam int PAGES_PER_BLOCK = 256;

    // Field widths
    localparam int ID_W      = 10;
    localparam int VP_W      = 9;
    localparam int OUT_CNT_W = 11;
    localparam int ID_SPACE  = 1 << ID_W;

    // Derived widths of list positions and counts
    localparam int SLOT_W = $clog2(BLOCKS);
    localparam int CNT_W  = $clog2(BLOCKS + 1);
    localparam int SUM_W  = CNT_W + 1;

    // Request modes
    localparam logic [2:0] MODE_APPEND  = 3'd0;
    localparam logic [2:0] MODE_SET_VP  = 3'd1;
    localparam logic [2:0] MODE_ROTATE  = 3'd2;
    localparam logic [2:0] MODE_VICTIM  = 3'd3;
    localparam logic [2:0] MODE_ALLOC   = 3'd4;
    localparam logic [2:0] MODE_RELEASE = 3'd5;

    // Order memory write and read requests
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [ID_W-1:0]   data;
    } ord_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } ord_rd_t;

    // Valid-count memory write and read requests
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] addr;
        logic [VP_W-1:0] data;
    } vt_wr_t;

    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] addr;
    } vt_rd_t;

    // Finished result of one transaction
    typedef struct packed {
        logic [ID_W-1:0]  chosen_block;
        logic [VP_W-1:0]  chosen_valid;
        logic [CNT_W-1:0] list_count;
        logic [CNT_W-1:0] free_count;
        logic             error;
    } res_t;

    // List position base + off, wrapped around the circular buffer
    function automatic logic [SLOT_W-1:0] slot_of(logic [SLOT_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(BLOCKS))
            sum = sum - SUM_W'(BLOCKS);
        return sum[SLOT_W-1:0];
    endfunction

    // Saturate a valid page count at the block size
    function automatic logic [VP_W-1:0] clamp_valid(logic [VP_W-1:0] v);
        if (32'(v) > PAGES_PER_BLOCK)
            return VP_W'(PAGES_PER_BLOCK);
        return v;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/flash_plane_block_list_gc_victim_unit.sv
// Top level of the flash plane block list and greedy GC victim unit.
`default_nettype none
`include "flash_plane_block_list_gc_victim_unit_defines.svh"

// Keeps one plane's ordered list of full blocks in a circular buffer memory,
// a memory of valid page counts indexed by block number, and the free-block
// count. One transaction is taken at a time; its result waits in an output
// register, so the next transaction is taken while that result is stalled.
// Append, set-valid, allocate, release and every refused request go straight
// to the result. Rotate reads the order memory, then the count memory. Victim
// take streams the list through the single read port of the order memory, one
// entry per cycle, and then closes the gap when the victim is not the last
// entry. Both memories start undefined and need no clearing pass; the unit
// takes transactions right after reset.
module flash_plane_block_list_gc_victim_unit
    import fpgc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [2:0]           mode,
    input  wire logic [ID_W-1:0]      block_id,
    input  wire logic [VP_W-1:0]      valid_pages,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [ID_W-1:0]      chosen_block,
    output logic      [VP_W-1:0]      chosen_valid,
    output logic      [OUT_CNT_W-1:0] list_count,
    output logic      [OUT_CNT_W-1:0] free_count,
    output logic                      error
);

    ord_wr_t          ord_wr;
    ord_rd_t          ord_rd;
    logic [ID_W-1:0]  ord_rd_data;
    vt_wr_t           vt_wr;
    vt_rd_t           vt_rd;
    logic [VP_W-1:0]  vt_rd_data;
    logic             res_vld;
    res_t             res;
    logic             res_ready;
    logic             out_load;

    logic             out_valid_reg, out_valid_next;
    res_t             out_res_reg;

    // Sequencer
    fpgc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .block_id    (block_id),
        .valid_pages (valid_pages),
        .ord_wr      (ord_wr),
        .ord_rd      (ord_rd),
        .ord_rd_data (ord_rd_data),
        .vt_wr       (vt_wr),
        .vt_rd       (vt_rd),
        .vt_rd_data  (vt_rd_data),
        .res_vld     (res_vld),
        .res         (res),
        .res_ready   (res_ready)
    );

    // Block order in list sequence
    fpgc_ram #(
        .WIDTH (ID_W),
        .DEPTH (BLOCKS)
    ) u_order_ram (
        .clk     (clk),
        .wr_en   (ord_wr.en),
        .wr_addr (ord_wr.addr),
        .wr_data (ord_wr.data),
        .rd_en   (ord_rd.en),
        .rd_addr (ord_rd.addr),
        .rd_data (ord_rd_data)
    );

    // Valid page count per block number
    fpgc_ram #(
        .WIDTH (VP_W),
        .DEPTH (ID_SPACE)
    ) u_valid_ram (
        .clk     (clk),
        .wr_en   (vt_wr.en),
        .wr_addr (vt_wr.addr),
        .wr_data (vt_wr.data),
        .rd_en   (vt_rd.en),
        .rd_addr (vt_rd.addr),
        .rd_data (vt_rd_data)
    );

    // Output register: load when empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;
    assign out_load  = res_vld && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign chosen_block = out_res_reg.chosen_block;
    assign chosen_valid = out_res_reg.chosen_valid;
    assign list_count   = OUT_CNT_W'(out_res_reg.list_count);
    assign free_count   = OUT_CNT_W'(out_res_reg.free_count);
    assign error        = out_res_reg.error;

    // Checks
    `FPGC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted transaction did not busy the sequencer")
    `FPGC_ASSERT_IMPL(a_refused_no_block, out_valid_reg && out_res_reg.error, out_res_reg.chosen_block == '0 && out_res_reg.chosen_valid == '0, "refused transaction returned a block")
    `FPGC_ASSERT_IMPL(a_list_bound, out_valid_reg, 32'(out_res_reg.list_count) <= BLOCKS, "list length above block count")
    `FPGC_ASSERT_IMPL(a_free_bound, out_valid_reg, 32'(out_res_reg.free_count) <= BLOCKS, "free count above block count")

endmodule

`default_nettype wire

### hw/rtl/fpgc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module fpgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/fpgc_ctrl.sv
// Sequencer of the block list: decodes a request, drives both memories, builds the result.
`default_nettype none

module fpgc_ctrl
    import fpgc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    // request side
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [2:0]      mode,
    input  wire logic [ID_W-1:0] block_id,
    input  wire logic [VP_W-1:0] valid_pages,
    // order memory
    output ord_wr_t              ord_wr,
    output ord_rd_t              ord_rd,
    input  wire logic [ID_W-1:0] ord_rd_data,
    // valid-count memory
    output vt_wr_t               vt_wr,
    output vt_rd_t               vt_rd,
    input  wire logic [VP_W-1:0] vt_rd_data,
    // result toward the output register
    output logic                 res_vld,
    output res_t                 res,
    input  wire logic            res_ready
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROT_A = 6'b000010,
        ST_ROT_B = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_SHIFT = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] free_reg, free_next;

    // scan / compaction pipeline
    logic [CNT_W-1:0] rd_off_reg, rd_off_next;
    logic             p1_vld_reg, p1_vld_next;
    logic [CNT_W-1:0] p1_off_reg, p1_off_next;
    logic             p2_vld_reg, p2_vld_next;
    logic [CNT_W-1:0] p2_off_reg, p2_off_next;
    logic [ID_W-1:0]  p2_id_reg, p2_id_next;
    logic [CNT_W-1:0] best_off_reg, best_off_next;
    logic [VP_W-1:0]  best_v_reg, best_v_next;
    logic [ID_W-1:0]  best_id_reg, best_id_next;

    // result payload
    logic [ID_W-1:0]  res_block_reg, res_block_next;
    logic [VP_W-1:0]  res_vp_reg, res_vp_next;
    logic             res_err_reg, res_err_next;

    // candidate that arrives from the valid-count memory this cycle
    logic             take_cand;
    logic [CNT_W-1:0] fin_off;
    logic [VP_W-1:0]  fin_v;
    logic [ID_W-1:0]  fin_id;
    logic [CNT_W-1:0] fin_next_off;
    logic             scan_last;

    assign take_cand    = p2_vld_reg && ((p2_off_reg == '0) || (vt_rd_data < best_v_reg));
    assign fin_off      = take_cand ? p2_off_reg : best_off_reg;
    assign fin_v        = take_cand ? vt_rd_data : best_v_reg;
    assign fin_id       = take_cand ? p2_id_reg : best_id_reg;
    assign fin_next_off = fin_off + CNT_W'(1);
    assign scan_last    = p2_vld_reg && (p2_off_reg == len_reg - CNT_W'(1));

    // Next-state and memory request logic
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        len_next       = len_reg;
        free_next      = free_reg;
        rd_off_next    = rd_off_reg;
        p1_vld_next    = p1_vld_reg;
        p1_off_next    = p1_off_reg;
        p2_vld_next    = p2_vld_reg;
        p2_off_next    = p2_off_reg;
        p2_id_next     = p2_id_reg;
        best_off_next  = best_off_reg;
        best_v_next    = best_v_reg;
        best_id_next   = best_id_reg;
        res_block_next = res_block_reg;
        res_vp_next    = res_vp_reg;
        res_err_next   = res_err_reg;
        ord_wr         = '0;
        ord_rd         = '0;
        vt_wr          = '0;
        vt_rd          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_block_next = '0;
                    res_vp_next    = '0;
                    res_err_next   = 1'b0;
                    state_next     = ST_DONE;
                    unique case (mode)
                        MODE_APPEND:
                        begin
                            if (len_reg == CNT_W'(BLOCKS))
                                res_err_next = 1'b1;
                            else
                            begin
                                ord_wr   = '{en: 1'b1, addr: slot_of(head_reg, len_reg),
                                             data: block_id};
                                vt_wr    = '{en: 1'b1, addr: block_id,
                                             data: clamp_valid(valid_pages)};
                                len_next = len_reg + CNT_W'(1);
                            end
                        end
                        MODE_SET_VP:
                        begin
                            vt_wr = '{en: 1'b1, addr: block_id,
                                      data: clamp_valid(valid_pages)};
                        end
                        MODE_ROTATE:
                        begin
                            if (len_reg == '0)
                                res_err_next = 1'b1;
                            else
                            begin
                                ord_rd     = '{en: 1'b1, addr: head_reg};
                                state_next = ST_ROT_A;
                            end
                        end
                        MODE_VICTIM:
                        begin
                            if (len_reg == '0)
                                res_err_next = 1'b1;
                            else
                            begin
                                ord_rd      = '{en: 1'b1, addr: head_reg};
                                rd_off_next = CNT_W'(1);
                                p1_vld_next = 1'b1;
                                p1_off_next = '0;
                                p2_vld_next = 1'b0;
                                state_next  = ST_SCAN;
                            end
                        end
                        MODE_ALLOC:
                        begin
                            if (free_reg == '0)
                                res_err_next = 1'b1;
                            else
                                free_next = free_reg - CNT_W'(1);
                        end
                        MODE_RELEASE:
                        begin
                            if (free_reg >= CNT_W'(BLOCKS))
                                res_err_next = 1'b1;
                            else
                                free_next = free_reg + CNT_W'(1);
                        end
                        default:
                        begin
                            res_err_next = 1'b0;
                        end
                    endcase
                end
            end

            // Front entry arrived: fetch its count, append it at the back, advance head
            ST_ROT_A:
            begin
                vt_rd          = '{en: 1'b1, addr: ord_rd_data};
                res_block_next = ord_rd_data;
                ord_wr         = '{en: 1'b1, addr: slot_of(head_reg, len_reg),
                                   data: ord_rd_data};
                head_next      = slot_of(head_reg, CNT_W'(1));
                state_next     = ST_ROT_B;
            end

            ST_ROT_B:
            begin
                res_vp_next = vt_rd_data;
                state_next  = ST_DONE;
            end

            // Stream the list: order read, count read, compare
            ST_SCAN:
            begin
                if (rd_off_reg < len_reg)
                begin
                    ord_rd      = '{en: 1'b1, addr: slot_of(head_reg, rd_off_reg)};
                    rd_off_next = rd_off_reg + CNT_W'(1);
                    p1_vld_next = 1'b1;
                    p1_off_next = rd_off_reg;
                end
                else
                    p1_vld_next = 1'b0;

                if (p1_vld_reg)
                begin
                    vt_rd       = '{en: 1'b1, addr: ord_rd_data};
                    p2_vld_next = 1'b1;
                    p2_off_next = p1_off_reg;
                    p2_id_next  = ord_rd_data;
                end
                else
                    p2_vld_next = 1'b0;

                best_off_next = fin_off;
                best_v_next   = fin_v;
                best_id_next  = fin_id;

                if (scan_last)
                begin
                    res_block_next = fin_id;
                    res_vp_next    = fin_v;
                    p1_vld_next    = 1'b0;
                    p2_vld_next    = 1'b0;
                    if (fin_next_off < len_reg)
                    begin
                        rd_off_next = fin_next_off;
                        state_next  = ST_SHIFT;
                    end
                    else
                    begin
                        len_next   = len_reg - CNT_W'(1);
                        state_next = ST_DONE;
                    end
                end
            end

            // Close the gap: move each later entry one place forward
            ST_SHIFT:
            begin
                if (p1_vld_reg)
                begin
                    ord_wr        = '{en: 1'b1, addr: slot_of(head_reg, best_off_reg),
                                      data: ord_rd_data};
                    best_off_next = best_off_reg + CNT_W'(1);
                end

                if (rd_off_reg < len_reg)
                begin
                    ord_rd      = '{en: 1'b1, addr: slot_of(head_reg, rd_off_reg)};
                    rd_off_next = rd_off_reg + CNT_W'(1);
                    p1_vld_next = 1'b1;
                end
                else
                begin
                    p1_vld_next = 1'b0;
                    len_next    = len_reg - CNT_W'(1);
                    state_next  = ST_DONE;
                end
            end

            // Hold the result until the output register takes it
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            len_reg    <= '0;
            free_reg   <= CNT_W'(BLOCKS);
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            len_reg    <= len_next;
            free_reg   <= free_next;
            p1_vld_reg <= p1_vld_next;
            p2_vld_reg <= p2_vld_next;
        end
    end

    // Pipeline and result payload
    always_ff @(posedge clk)
    begin
        rd_off_reg    <= rd_off_next;
        p1_off_reg    <= p1_off_next;
        p2_off_reg    <= p2_off_next;
        p2_id_reg     <= p2_id_next;
        best_off_reg  <= best_off_next;
        best_v_reg    <= best_v_next;
        best_id_reg   <= best_id_next;
        res_block_reg <= res_block_next;
        res_vp_reg    <= res_vp_next;
        res_err_reg   <= res_err_next;
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign res_vld  = (state_reg == ST_DONE);
    assign res      = '{chosen_block: res_block_reg, chosen_valid: res_vp_reg,
                        list_count: len_reg, free_count: free_reg, error: res_err_reg};

endmodule

`default_nettype wire

### tb/sv/plane_list_checker.sv
// Checker for the flash plane block list unit: predicts each result and compares it.
module plane_list_checker
    import fpgc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic [2:0]           mode,
    input  wire logic [ID_W-1:0]      block_id,
    input  wire logic [VP_W-1:0]      valid_pages,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [ID_W-1:0]      chosen_block,
    input  wire logic [VP_W-1:0]      chosen_valid,
    input  wire logic [OUT_CNT_W-1:0] list_count,
    input  wire logic [OUT_CNT_W-1:0] free_count,
    input  wire logic                 error,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 200;

    // Shadow copy of the plane's block list, valid counts and free count
    logic [ID_W-1:0]   order_mem [BLOCKS];
    logic [VP_W-1:0]   valid_mem [ID_SPACE];
    logic [SLOT_W-1:0] head_q;
    int unsigned       len_q;
    int unsigned       free_q;

    // Results still owed by the unit, oldest first
    res_t awaited_results[$];
    res_t want_r;
    res_t new_r;
    int   init_idx;

    // List position at offset off from the front, wrapped around the ring
    function automatic logic [SLOT_W-1:0] ring_pos(int unsigned off);
        return SLOT_W'((int'(head_q) + off) % BLOCKS);
    endfunction

    // Print one line per mismatch (capped) and count it
    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Apply one transaction to the shadow state and form its result
    task automatic compute_plane_result(input logic [2:0] m, input logic [ID_W-1:0] id,
                                        input logic [VP_W-1:0] vp_raw, output res_t r);
        logic [VP_W-1:0] vp;
        logic [ID_W-1:0] front;
        int unsigned     best;
        int unsigned     best_v;
        int unsigned     v;
        int unsigned     i;
        vp = (int'(vp_raw) > PAGES_PER_BLOCK) ? VP_W'(PAGES_PER_BLOCK) : vp_raw;
        r = '0;
        case (m)
            MODE_APPEND:
                if (len_q >= BLOCKS)
                    r.error = 1'b1;
                else
                begin
                    order_mem[ring_pos(len_q)] = id;
                    valid_mem[id] = vp;
                    len_q++;
                end
            MODE_SET_VP:
                valid_mem[id] = vp;
            MODE_ROTATE:
                if (len_q == 0)
                    r.error = 1'b1;
                else
                begin
                    front = order_mem[ring_pos(0)];
                    r.chosen_block = front;
                    r.chosen_valid = valid_mem[front];
                    order_mem[ring_pos(len_q)] = front;
                    head_q = ring_pos(1);
                end
            MODE_VICTIM:
                if (len_q == 0)
                    r.error = 1'b1;
                else
                begin
                    // Scan from the front; keep the first entry with the fewest pages
                    best = 0;
                    best_v = valid_mem[order_mem[ring_pos(0)]];
                    for (i = 1; i < len_q; i++)
                    begin
                        v = valid_mem[order_mem[ring_pos(i)]];
                        if (v < best_v)
                        begin
                            best_v = v;
                            best = i;
                        end
                    end
                    r.chosen_block = order_mem[ring_pos(best)];
                    r.chosen_valid = VP_W'(best_v);
                    // Close the gap, keeping the order of the rest
                    for (i = best; i + 1 < len_q; i++)
                        order_mem[ring_pos(i)] = order_mem[ring_pos(i + 1)];
                    len_q--;
                end
            MODE_ALLOC:
                if (free_q == 0)
                    r.error = 1'b1;
                else
                    free_q--;
            MODE_RELEASE:
                if (free_q >= BLOCKS)
                    r.error = 1'b1;
                else
                    free_q++;
            default:
                ;
        endcase
        r.list_count = CNT_W'(len_q);
        r.free_count = CNT_W'(free_q);
    endtask

    // Compare accepted results, then predict for accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (init_idx = 0; init_idx < BLOCKS; init_idx++)
                order_mem[init_idx] = '0;
            for (init_idx = 0; init_idx < ID_SPACE; init_idx++)
                valid_mem[init_idx] = '0;
            head_q = '0;
            len_q = 0;
            free_q = BLOCKS;
            awaited_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with nothing awaited, chosen_block", chosen_block, 0);
                else
                begin
                    want_r = awaited_results[0];
                    awaited_results.delete(0);
                    if (chosen_block !== want_r.chosen_block)
                        report_mismatch("chosen_block", chosen_block, want_r.chosen_block);
                    if (chosen_valid !== want_r.chosen_valid)
                        report_mismatch("chosen_valid", chosen_valid, want_r.chosen_valid);
                    if (list_count !== want_r.list_count)
                        report_mismatch("list_count", list_count, want_r.list_count);
                    if (free_count !== want_r.free_count)
                        report_mismatch("free_count", free_count, want_r.free_count);
                    if (error !== want_r.error)
                        report_mismatch("error", error, want_r.error);
                end
            end
            if (in_valid && !in_stall)
            begin
                compute_plane_result(mode, block_id, valid_pages, new_r);
                awaited_results.insert(awaited_results.size(), new_r);
            end
            pending = awaited_results.size();
        end
    end

endmodule

### tb/sv/tb.sv
// Testbench top for the flash plane block list unit: stimulus, pacing and verdict.
module tb;
    import fpgc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 31;
    localparam int STALL_LIMIT  = 12000;
    localparam int TAIL_CYCLES  = 2 * BLOCKS + 16;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [2:0]           mode;
    logic [ID_W-1:0]      block_id;
    logic [VP_W-1:0]      valid_pages;
    logic                 out_valid;
    logic                 out_stall;
    logic [ID_W-1:0]      chosen_block;
    logic [VP_W-1:0]      chosen_valid;
    logic [OUT_CNT_W-1:0] list_count;
    logic [OUT_CNT_W-1:0] free_count;
    logic                 error;

    int fail_count;
    int pending;

    // Pacing controls: steady is shared by the sender and the receiver, hold_req drives the receiver
    logic steady;
    logic hold_req;

    int              quiet_cycles;
    logic [ID_W-1:0] id_pool [16];

    flash_plane_block_list_gc_victim_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .block_id     (block_id),
        .valid_pages  (valid_pages),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .chosen_block (chosen_block),
        .chosen_valid (chosen_valid),
        .list_count   (list_count),
        .free_count   (free_count),
        .error        (error)
    );

    plane_list_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .block_id     (block_id),
        .valid_pages  (valid_pages),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .chosen_block (chosen_block),
        .chosen_valid (chosen_valid),
        .list_count   (list_count),
        .free_count   (free_count),
        .error        (error),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Free-running clock
    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one transaction, idling first at random, and hold it until taken
    task automatic send_req(input logic [2:0] m, input logic [ID_W-1:0] id,
                            input logic [VP_W-1:0] vp);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode = m;
        block_id = id;
        valid_pages = vp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Draw a page count: many small values for ties, some past the clamp
    function automatic logic [VP_W-1:0] pick_pages();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return VP_W'($urandom_range(0, 3));
        if (r < 50)
            return ($urandom_range(0, 1) != 0) ? VP_W'(PAGES_PER_BLOCK) : VP_W'(511);
        return VP_W'($urandom_range(0, 511));
    endfunction

    // Draw a block number, often from a small pool so blocks repeat
    function automatic logic [ID_W-1:0] pick_block();
        if ($urandom_range(0, 1) != 0)
            return id_pool[$urandom_range(0, 15)];
        return ID_W'($urandom_range(0, 1023));
    endfunction

    // Random mix weighted so the list grows slowly and still empties early
    task automatic send_random_req();
        int       r;
        logic [2:0] m;
        r = $urandom_range(0, 99);
        if (r < 30)
            m = MODE_APPEND;
        else if (r < 45)
            m = MODE_SET_VP;
        else if (r < 60)
            m = MODE_ROTATE;
        else if (r < 78)
            m = MODE_VICTIM;
        else if (r < 87)
            m = MODE_ALLOC;
        else if (r < 96)
            m = MODE_RELEASE;
        else if (r < 98)
            m = MODE_SPARE_6;
        else
            m = MODE_SPARE_7;
        send_req(m, pick_block(), pick_pages());
    endtask

    // Receiver: random stall, one long hold-off on request
    initial
    begin : result_sink
        logic hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else
                out_stall = !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus and verdict
    initial
    begin
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_APPEND;
        block_id = '0;
        valid_pages = '0;
        steady = 1'b0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        for (i = 0; i < 16; i++)
            id_pool[i] = ID_W'($urandom_range(0, 1023));
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: refusals on an empty list and a full free pool, then the spare modes
        send_req(MODE_ROTATE, 10'd0, 9'd0);
        send_req(MODE_VICTIM, 10'd0, 9'd0);
        send_req(MODE_RELEASE, 10'd0, 9'd0);
        send_req(MODE_SPARE_6, 10'd1023, 9'd511);
        send_req(MODE_SPARE_7, 10'd1023, 9'd511);
        // Directed: field extremes, clamping and a repeated block
        send_req(MODE_APPEND, 10'd0, 9'd0);
        send_req(MODE_APPEND, 10'd1023, 9'd511);
        send_req(MODE_APPEND, 10'd5, 9'd256);
        send_req(MODE_APPEND, 10'd7, 9'd257);
        send_req(MODE_APPEND, 10'd5, 9'd3);
        send_req(MODE_SET_VP, 10'd1023, 9'd0);
        // Directed: rotate, then victims with a tie on the lowest count
        send_req(MODE_ROTATE, 10'd0, 9'd0);
        send_req(MODE_VICTIM, 10'd0, 9'd0);
        send_req(MODE_VICTIM, 10'd0, 9'd0);
        send_req(MODE_ALLOC, 10'd0, 9'd0);
        send_req(MODE_RELEASE, 10'd0, 9'd0);
        send_req(MODE_SET_VP, 10'd7, 9'd1);
        send_req(MODE_VICTIM, 10'd0, 9'd0);
        send_req(MODE_VICTIM, 10'd0, 9'd0);
        send_req(MODE_VICTIM, 10'd0, 9'd0);
        send_req(MODE_VICTIM, 10'd0, 9'd0);
        send_req(MODE_SET_VP, 10'h2AA, 9'h155);
        send_req(MODE_APPEND, 10'h155, 9'h0AA);

        // Random mix with one long receiver hold-off, one full drain and
        // one stretch with no idling on either side
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 100)
                hold_req = 1'b1;
            if (i == 150)
                steady = 1'b1;
            if (i == 190)
                steady = 1'b0;
            if (i == 200)
            begin
                in_valid = 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            send_random_req();
        end

        // Work on the remaining list: rotate, update, take and append
        for (i = 0; i < 3; i++)
        begin
            send_req(MODE_ROTATE, 10'd0, 9'd0);
            send_req(MODE_SET_VP, pick_block(), pick_pages());
            send_req(MODE_VICTIM, 10'd0, 9'd0);
            send_req(MODE_APPEND, pick_block(), pick_pages());
        end
        in_valid = 1'b0;

        // Drain, then allow for a stray late result
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/fpgc_pkg.sv
hw/rtl/fpgc_ram.sv
hw/rtl/fpgc_ctrl.sv
hw/rtl/flash_plane_block_list_gc_victim_unit.sv
tb/sv/plane_list_checker.sv
tb/sv/tb.sv
